/* hw/rtl/rdc_pkg.sv */
// Package for the radix digit converter: field widths, ASCII constants and
// the digit-to-character function. Depends on nothing; every other file imports it.
`default_nettype none

package rdc_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned ValueW = 32;
  localparam int unsigned RadixW = 5;
  localparam int unsigned CharW  = 7;
  localparam int unsigned DigitW = 4;

  // Bits of quotient produced per divider cycle.
  localparam int unsigned SliceW = 8;

  // Base limits after clamping.
  localparam logic [RadixW-1:0] BaseMin = RadixW'(2);
  localparam logic [RadixW-1:0] BaseMax = RadixW'(16);

  // ASCII codes of the digit glyphs.
  localparam logic [CharW-1:0] CharZero   = 7'd48;  // '0'
  localparam logic [CharW-1:0] CharLetter = 7'd65;  // 'A'
  localparam logic [CharW-1:0] CharTop    = 7'd70;  // 'F'
  localparam logic [CharW-1:0] CharNine   = 7'd57;  // '9'

  // Status from the back end, watched at the top level.
  typedef struct packed {
    logic              dividing;
    logic              emitting;
    logic [RadixW-1:0] base;
  } rdc_status_t;

  // Map a digit 0..15 to its ASCII glyph.
  function automatic logic [CharW-1:0] glyph(input logic [DigitW-1:0] d);
    logic [CharW-1:0] ch;
    if (d < DigitW'(10)) begin
      ch = CharZero + CharW'(d);
    end else begin
      ch = CharLetter + CharW'(d - DigitW'(10));
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rdc_if.sv */
// Handshake interfaces for the input and output channels of the converter.
// Depends on rdc_pkg for the field widths.
`default_nettype none

// Input channel: one number and its target base per transaction.
interface rdc_in_if
  import rdc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic [RadixW-1:0] radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

// Output channel: one ASCII digit per transaction.
interface rdc_out_if
  import rdc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] digit_char;
  logic             last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rdc_front.sv */
// Front end of the converter: accepts transactions, masks the value, clamps
// the base and holds jobs in a two-entry queue. Depends on rdc_pkg and rdc_if.
`default_nettype none

module rdc_front
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  rdc_in_if.sink                     in_i,
  output logic                       job_valid_o,
  input  wire logic                  job_ready_i,
  output logic [VALUE_BITS-1:0]      job_value_o,
  output logic [RadixW-1:0]          job_base_o
);

  localparam int unsigned Depth = 2;

  logic [VALUE_BITS-1:0] val_q  [Depth];
  logic [RadixW-1:0]     base_q [Depth];
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  push, pop;
  logic [RadixW-1:0]     base_clamped;

  // Clamp the base into 2..16.
  always_comb begin
    priority if (in_i.radix < BaseMin) begin
      base_clamped = BaseMin;
    end else if (in_i.radix > BaseMax) begin
      base_clamped = BaseMax;
    end else begin
      base_clamped = in_i.radix;
    end
  end

  assign in_i.ready  = (cnt_q != 2'(Depth));
  assign push        = in_i.valid && in_i.ready;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_value_o = val_q[rd_ptr_q];
  assign job_base_o  = base_q[rd_ptr_q];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue payload; only the low VALUE_BITS of the value are kept.
  always_ff @(posedge clk_i) begin
    if (push) begin
      val_q[wr_ptr_q]  <= VALUE_BITS'(in_i.value);
      base_q[wr_ptr_q] <= base_clamped;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rdc_div_slice.sv */
// One divider cycle: eight restoring division steps of a byte by a base of
// at most 16, carrying a four-bit remainder. Depends on rdc_pkg.
`default_nettype none

module rdc_div_slice
  import rdc_pkg::*;
(
  input  wire logic [DigitW-1:0] rem_i,
  input  wire logic [SliceW-1:0] byte_i,
  input  wire logic [RadixW-1:0] base_i,
  output logic      [DigitW-1:0] rem_o,
  output logic      [SliceW-1:0] quo_o
);

  // The remainder stays below the base, so four bits hold it between steps.
  always_comb begin
    logic [DigitW-1:0] r;
    logic [RadixW-1:0] t;
    r     = rem_i;
    quo_o = '0;
    for (int i = SliceW - 1; i >= 0; i--) begin
      t = {r, byte_i[i]};
      if (t >= base_i) begin
        r        = DigitW'(t - base_i);
        quo_o[i] = 1'b1;
      end else begin
        r = DigitW'(t);
      end
    end
    rem_o = r;
  end

endmodule

`default_nettype wire

/* hw/rtl/rdc_back.sv */
// Back end of the converter: divides a job into digits, keeps them in the
// digit store and emits them most significant first. Depends on rdc_pkg,
// rdc_if and rdc_div_slice.
`default_nettype none

module rdc_back
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_DIGITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  job_valid_i,
  output logic                       job_ready_o,
  input  wire logic [VALUE_BITS-1:0] job_value_i,
  input  wire logic [RadixW-1:0]     job_base_i,
  rdc_out_if.source                  out_o,
  output rdc_status_t                status_o
);

  localparam int unsigned Steps = (VALUE_BITS + SliceW - 1) / SliceW;
  localparam int unsigned PadW  = Steps * SliceW;
  localparam int unsigned StepW = $clog2(Steps + 1);
  localparam int unsigned AddrW = $clog2(MAX_DIGITS);
  localparam int unsigned CntW  = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StEmit
  } state_e;

  state_e            state_q;
  logic [PadW-1:0]   dvd_q;
  logic [RadixW-1:0] base_q;
  logic [DigitW-1:0] rem_q;
  logic [StepW-1:0]  step_q;
  logic [CntW-1:0]   n_q;
  logic [AddrW-1:0]  pos_q;

  // Digit store and its registered read port.
  logic [DigitW-1:0] mem [MAX_DIGITS];
  logic [DigitW-1:0] rd_digit_q;
  logic              rd_last_q;
  logic              pend_q;

  // Output register.
  logic              out_vld_q;
  logic [CharW-1:0]  out_char_q;
  logic              out_last_q;

  logic [DigitW-1:0] rem_new;
  logic [SliceW-1:0] quo_byte;
  logic [PadW-1:0]   dvd_next;
  logic [CntW-1:0]   n_next;
  logic              digit_done;
  logic              rd_en;
  logic              move;

  rdc_div_slice u_slice (
    .rem_i  (rem_q),
    .byte_i (dvd_q[PadW-1 -: SliceW]),
    .base_i (base_q),
    .rem_o  (rem_new),
    .quo_o  (quo_byte)
  );

  // The quotient bits shift in at the bottom as the dividend shifts out.
  assign dvd_next    = (dvd_q << SliceW) | PadW'(quo_byte);
  assign n_next      = n_q + CntW'(1);
  assign digit_done  = (state_q == StDiv) && (step_q == StepW'(Steps - 1));
  assign job_ready_o = (state_q == StIdle);

  // Read the store whenever the read register will be free.
  assign move  = pend_q && (!out_vld_q || out_o.ready);
  assign rd_en = (state_q == StEmit) && (!pend_q || move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      n_q     <= '0;
      pos_q   <= '0;
      rem_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            state_q <= StDiv;
            step_q  <= '0;
            n_q     <= '0;
            rem_q   <= '0;
          end
        end
        StDiv: begin
          if (digit_done) begin
            step_q <= '0;
            rem_q  <= '0;
            if ((dvd_next == '0) || (n_next == CntW'(MAX_DIGITS))) begin
              state_q <= StEmit;
              pos_q   <= AddrW'(n_q);
            end else begin
              n_q <= n_next;
            end
          end else begin
            step_q <= step_q + StepW'(1);
            rem_q  <= rem_new;
          end
        end
        StEmit: begin
          if (rd_en) begin
            if (pos_q == '0) begin
              state_q <= StIdle;
            end else begin
              pos_q <= pos_q - AddrW'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Dividend and base of the job in progress.
  always_ff @(posedge clk_i) begin
    if (job_ready_o && job_valid_i) begin
      dvd_q  <= PadW'(job_value_i);
      base_q <= job_base_i;
    end else if (state_q == StDiv) begin
      dvd_q <= dvd_next;
    end
  end

  // Digit store write and registered read.
  always_ff @(posedge clk_i) begin
    if (digit_done) begin
      mem[AddrW'(n_q)] <= rem_new;
    end
    if (rd_en) begin
      rd_digit_q <= mem[pos_q];
      rd_last_q  <= (pos_q == '0);
    end
  end

  // Valid flags of the read register and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pend_q    <= (pend_q && !move) || rd_en;
      out_vld_q <= move || (out_vld_q && !out_o.ready);
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (move) begin
      out_char_q <= glyph(rd_digit_q);
      out_last_q <= rd_last_q;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.digit_char = out_char_q;
  assign out_o.last       = out_last_q;

  assign status_o.dividing = (state_q == StDiv);
  assign status_o.emitting = (state_q == StEmit);
  assign status_o.base     = base_q;

endmodule

`default_nettype wire

/* hw/rtl/radix_digit_converter_top.sv */
// Radix digit converter. A number is loaded, then divided repeatedly by the
// base through a byte-wide divider loop, one remainder digit per division; the
// digits then leave as output transactions at one per cycle while the output is
// ready, through the store read register and the output register. A two-entry
// queue accepts new items while the back end is busy. Reset is asynchronous and
// clears control only.
`default_nettype none

module radix_digit_converter_top
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_DIGITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rdc_in_if.sink    in_i,
  rdc_out_if.source out_o
);

  logic                  job_valid;
  logic                  job_ready;
  logic [VALUE_BITS-1:0] job_value;
  logic [RadixW-1:0]     job_base;
  rdc_status_t           status;

  rdc_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_value_o (job_value),
    .job_base_o  (job_base)
  );

  rdc_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_value_i (job_value),
    .job_base_i  (job_base),
    .out_o       (out_o),
    .status_o    (status)
  );

`ifndef SYNTHESIS
  // Every emitted character is a valid digit glyph.
  a_char_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.digit_char >= CharZero && out_o.digit_char <= CharNine) ||
                     (out_o.digit_char >= CharLetter && out_o.digit_char <= CharTop)))
    else $error("output character is not a digit glyph");

  // The divider only ever works with a clamped base.
  a_base_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.dividing |-> (status.base >= BaseMin && status.base <= BaseMax))
    else $error("divider running with a base outside 2..16");

  // A job is taken only while the back end is neither dividing nor emitting.
  a_job_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid && job_ready) |-> (!status.dividing && !status.emitting))
    else $error("job taken while the back end is busy");
`endif

endmodule

`default_nettype wire
